@@ rtl/multi_operand_gcd_assert.svh @@
// Assertion macros for the GCD block; they sample i_clk and i_rst_n of the including module.
`ifndef MULTI_OPERAND_GCD_ASSERT_SVH
`define MULTI_OPERAND_GCD_ASSERT_SVH

// Same-cycle implication.
`define MOG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define MOG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/mog_pkg.sv @@
`timescale 1ns / 1ps
package mog_pkg;
    localparam int VALUE_BITS_DEF = 31;
endpackage

@@ rtl/mog_in_if.sv @@
`timescale 1ns / 1ps
interface mog_in_if #(
    parameter int VALUE_BITS = mog_pkg::VALUE_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] value;
    logic                  last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

@@ rtl/mog_out_if.sv @@
`timescale 1ns / 1ps
interface mog_out_if #(
    parameter int VALUE_BITS = mog_pkg::VALUE_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] divisor;

    modport source (output valid, output divisor, input ready);
    modport sink   (input valid, input divisor, output ready);
endinterface

@@ rtl/multi_operand_gcd.sv @@
`timescale 1ns / 1ps
// Running GCD over a group of positive integers.
// Input channel i_in: one group member per beat (value), last marks the final member.
// Output channel o_out: one beat per group carrying divisor, the GCD of all members.
// Members that are not last produce no output beat.
// Operation: a beat is taken while idle, then the binary GCD loop runs on a single
// shared compare/subtract/shift unit, one step per cycle. Every step drops at least
// one bit of the two operands. After a last member the block passes through S_EMIT
// to load the result into the output register.
// i_in.ready is high only while the loop is idle, so a new member is taken only
// once the single step unit is through with the previous one.
// The result sits in an output register: the next group's members are accepted
// while it waits. If the receiver stalls and a second result is ready, the block
// holds that result and stops taking members until the output register frees.
// Reset (i_rst_n low, synchronous) clears the running GCD to zero (no member yet),
// empties the output register and returns the sequencer to idle.
// Zero inputs act as gcd(0, x) = x; an all-zero group yields divisor 0.
module multi_operand_gcd #(
    parameter int VALUE_BITS = mog_pkg::VALUE_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mog_in_if.sink    i_in,
    mog_out_if.source o_out
);
    import mog_pkg::*;

    localparam int KW = $clog2(VALUE_BITS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_EMIT
    } t_state;

    t_state                r_state, n_state;
    logic [VALUE_BITS-1:0] r_run, n_run;       // GCD of members so far, 0 = none
    logic [VALUE_BITS-1:0] r_a, n_a;
    logic [VALUE_BITS-1:0] r_b, n_b;
    logic [KW-1:0]         r_k, n_k;           // common factors of two removed
    logic                  r_last, n_last;
    logic                  r_out_valid, n_out_valid;
    logic [VALUE_BITS-1:0] r_out_div, n_out_div;

    // shared step unit
    logic                  a_ge_b;
    logic [VALUE_BITS-1:0] big, sml, diff, gcd_res;
    logic                  done, slot_free;

    assign a_ge_b    = (r_a >= r_b);
    assign big       = a_ge_b ? r_a : r_b;
    assign sml       = a_ge_b ? r_b : r_a;
    assign diff      = big - sml;
    assign done      = (r_a == '0) || (r_b == '0);
    assign gcd_res   = (r_a | r_b) << r_k;
    assign slot_free = !r_out_valid || o_out.ready;

    always_comb begin
        n_state     = r_state;
        n_run       = r_run;
        n_a         = r_a;
        n_b         = r_b;
        n_k         = r_k;
        n_last      = r_last;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_div   = r_out_div;
        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_a     = r_run;
                    n_b     = i_in.value;
                    n_last  = i_in.last;
                    n_k     = '0;
                    n_state = S_CALC;
                end
            end
            S_CALC: begin
                if (done) begin
                    n_run   = gcd_res;
                    n_state = r_last ? S_EMIT : S_IDLE;
                end else if (!r_a[0] && !r_b[0]) begin
                    n_a = r_a >> 1;
                    n_b = r_b >> 1;
                    n_k = r_k + KW'(1);
                end else if (!r_a[0]) begin
                    n_a = r_a >> 1;
                end else if (!r_b[0]) begin
                    n_b = r_b >> 1;
                end else if (a_ge_b) begin
                    n_a = diff >> 1;      // odd minus odd is even
                end else begin
                    n_b = diff >> 1;
                end
            end
            S_EMIT: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_div   = r_run;
                    n_run       = '0;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_run       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_run       <= n_run;
            r_out_valid <= n_out_valid;
        end
        r_a       <= n_a;
        r_b       <= n_b;
        r_k       <= n_k;
        r_last    <= n_last;
        r_out_div <= n_out_div;
    end

    assign i_in.ready    = (r_state == S_IDLE);
    assign o_out.valid   = r_out_valid;
    assign o_out.divisor = r_out_div;

`include "multi_operand_gcd_assert.svh"

    `MOG_ASSERT_NEXT(a_accept_starts, i_in.valid && i_in.ready, r_state == S_CALC, "accepted beat did not start the loop")
    `MOG_ASSERT_NOW(a_k_bound, r_state == S_CALC, r_k < KW'(VALUE_BITS), "common shift count out of range")
    `MOG_ASSERT_NOW(a_load_from_emit, $rose(r_out_valid), $past(r_state) == S_EMIT, "output loaded outside emit")
    `MOG_ASSERT_NEXT(a_emit_clears, r_state == S_EMIT && slot_free, r_run == '0 && r_out_valid, "group state not cleared after result")

endmodule

@@ bench/gcd_checker.sv @@
`timescale 1ns / 1ps
// Watches both channels, keeps its own running GCD and compares every
// divisor beat with the oldest predicted one.
module gcd_checker #(
    parameter int VALUE_BITS = mog_pkg::VALUE_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    mog_in_if    i_in_mon,
    mog_out_if   i_out_mon,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked
);
    logic [VALUE_BITS-1:0] running_divisor;
    logic [VALUE_BITS-1:0] expected_divisors[$];
    int                    fail_count;
    int                    checked;

    // Euclid; gcd(0, x) = x.
    function automatic logic [VALUE_BITS-1:0] euclid_gcd(input logic [VALUE_BITS-1:0] a,
                                                         input logic [VALUE_BITS-1:0] b);
        logic [VALUE_BITS-1:0] r;
        while (b != '0) begin
            r = a % b;
            a = b;
            b = r;
        end
        return a;
    endfunction

    always @(posedge i_clk) begin
        logic [VALUE_BITS-1:0] want;
        if (!i_rst_n) begin
            running_divisor = '0;
            expected_divisors.delete();
            fail_count = 0;
            checked    = 0;
        end else begin
            // Output first: a beat leaving now belongs to an earlier group.
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (expected_divisors.size() == 0) begin
                    $error("divisor beat %0d with nothing expected", i_out_mon.divisor);
                    fail_count++;
                end else begin
                    want = expected_divisors.pop_front();
                    checked++;
                    if (i_out_mon.divisor !== want) begin
                        $error("divisor mismatch: expected %0d, actual %0d",
                               want, i_out_mon.divisor);
                        fail_count++;
                    end
                end
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                running_divisor = euclid_gcd(running_divisor, i_in_mon.value);
                if (i_in_mon.last) begin
                    expected_divisors.push_back(running_divisor);
                    running_divisor = '0;
                end
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= expected_divisors.size();
        o_checked    <= checked;
    end
endmodule

@@ bench/tb_multi_operand_gcd.sv @@
`timescale 1ns / 1ps
// Top of the GCD bench: clock, reset, member stimulus and the receiver's
// ready pattern. All checking lives in gcd_checker; this module only turns
// its failure and pending counts (and the timeout) into the verdict.
module tb_multi_operand_gcd;
    localparam int VB = mog_pkg::VALUE_BITS_DEF;
    localparam longint unsigned VMAX = (64'd1 << VB) - 1;
    // Total members to send, directed part included; the rest are random.
    localparam int NUM_RANDOM = 1350;
    // Last stretch of the run goes without any idling.
    localparam int QUIET_TAIL = 200;
    // Worst loop length plus result load and some slack.
    localparam int DRAIN_CYCLES = 2 * VB + 16;

    logic i_clk;
    logic i_rst_n;

    mog_in_if  #(.VALUE_BITS(VB)) in_if ();
    mog_out_if #(.VALUE_BITS(VB)) out_if ();

    int fail_count;
    int pending;
    int checked;

    // Idle controls: sender gaps and receiver stalls.
    bit send_idle;
    bit stall_on;

    int members_sent;
    int groups_sent;

    multi_operand_gcd #(.VALUE_BITS(VB)) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if.sink),
        .o_out  (out_if.source)
    );

    gcd_checker #(.VALUE_BITS(VB)) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_mon    (in_if),
        .i_out_mon   (out_if),
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .o_checked   (checked)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver: ready held high or low in random bursts.
    // One nonblocking write per edge at most.
    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_on && $urandom_range(0, 2) == 0) begin
                out_if.ready <= 1'b0;
                repeat ($urandom_range(0, 7)) @(posedge i_clk);
            end else begin
                out_if.ready <= 1'b1;
                repeat ($urandom_range(0, 15)) @(posedge i_clk);
            end
        end
    end

    // One member beat. An optional idle gap comes first;
    // valid stays high across back-to-back beats (no drop within a step).
    // ready is read at the edge, before the block's updates land.
    task automatic send_member(input logic [VB-1:0] value, input logic last);
        if (send_idle && $urandom_range(0, 3) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.value <= value;
        in_if.last  <= last;
        do @(posedge i_clk); while (!in_if.ready);
        members_sent++;
        if (last)
            groups_sent++;
    endtask

    // Sender holds off until every predicted divisor has come out. The first
    // edge lets the checker register a last beat accepted just now.
    task automatic wait_drained();
        in_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin
        longint unsigned factor;
        longint unsigned span;
        int              group_len;

        // Known values on every input from time zero.
        i_rst_n     = 1'b0;
        in_if.valid = 1'b0;
        in_if.value = '0;
        in_if.last  = 1'b0;
        send_idle   = 1'b1;
        stall_on    = 1'b1;
        members_sent = 0;
        groups_sent  = 0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- Directed part ----
        // Single member groups: the smallest and the largest value.
        send_member(VB'(1), 1'b1);
        send_member(VB'(VMAX), 1'b1);
        // Two equal maximal members.
        send_member(VB'(VMAX), 1'b0);
        send_member(VB'(VMAX), 1'b1);
        // Neighbors at the top of the range are coprime.
        send_member(VB'(VMAX), 1'b0);
        send_member(VB'(VMAX - 1), 1'b1);
        // Shared power of two near the top bit.
        send_member(VB'(64'd1 << (VB - 1)), 1'b0);
        send_member(VB'(64'd3 << (VB - 2)), 1'b1);
        // A 1 in the middle of a group forces the result to 1.
        send_member(VB'(12), 1'b0);
        send_member(VB'(1), 1'b0);
        send_member(VB'(18), 1'b1);
        // A 1 first, then a large member.
        send_member(VB'(1), 1'b0);
        send_member(VB'(VMAX - 1), 1'b1);
        // Consecutive Fibonacci numbers: longest Euclid chain in range.
        send_member(VB'(1134903170), 1'b0);
        send_member(VB'(1836311903), 1'b1);
        // Alternating bit patterns.
        send_member(VB'(32'h5555_5555), 1'b0);
        send_member(VB'(32'h2AAA_AAAA), 1'b1);
        // Four members with a composite common factor (60).
        send_member(VB'(360), 1'b0);
        send_member(VB'(840), 1'b0);
        send_member(VB'(1260), 1'b0);
        send_member(VB'(2100), 1'b1);

        // Hold off until the directed divisors are all out.
        wait_drained();

        // ---- Random part ----
        // Groups of 1 to 6 members, all multiples of one chosen factor so the
        // group divisor is at least that factor and often more.
        while (members_sent < NUM_RANDOM) begin
            // Re-roll the idle pattern now and then; the tail stays quiet.
            if (groups_sent % 16 == 0) begin
                send_idle = ($urandom_range(0, 3) != 0);
                stall_on  = ($urandom_range(0, 3) != 0);
            end
            if (members_sent >= NUM_RANDOM - QUIET_TAIL) begin
                send_idle = 1'b0;
                stall_on  = 1'b0;
            end
            // Extra hold-off half way through, before each group that starts there.
            if (members_sent >= NUM_RANDOM / 2 && members_sent < NUM_RANDOM / 2 + 6)
                wait_drained();

            case ($urandom_range(0, 9))
                0, 1, 2: factor = 1;
                3, 4:    factor = $urandom_range(1000, 2);
                5, 6:    factor = 64'd1 << $urandom_range(VB - 1, 1);
                7, 8:    factor = $urandom_range(32'(VMAX), 1);
                default: factor = VMAX;
            endcase
            span = VMAX / factor;
            // Narrow multipliers keep extra common factors likely.
            if (span > 64 && $urandom_range(0, 1) == 0)
                span = 64;
            group_len = $urandom_range(6, 1);
            for (int m = 0; m < group_len; m++)
                send_member(VB'(factor * $urandom_range(32'(span), 1)), m == group_len - 1);
        end
        in_if.valid <= 1'b0;

        // Wait out every predicted divisor, then a loop's worth of cycles so
        // a stray beat would still be seen.
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d members in %0d groups (extremes, early ones, shared factors).",
                 members_sent, groups_sent);
        $display("Checked %0d divisor beats under random gaps and stalls.", checked);
        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Watchdog, several times the slowest legal run.
    initial begin
        #8_000_000;
        $display("Timeout with %0d divisors outstanding", pending);
        $display("Verification failed");
        $finish;
    end
endmodule
